### hdl/assert_macros.svh
// Assertion helpers. Both forms sample on i_clk and are disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_HOLDS(lbl, cond, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/krkf_pkg.sv
package krkf_pkg;

    localparam int RING_DEPTH = 16;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int TABLE_SIZE = 48;

    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [6:0] KEY_SPACE  = 7'h20;
    localparam logic [6:0] POS_MAX    = 7'd127;
    localparam logic [6:0] PAIR_START = 7'd4;

    localparam logic [6:0] KEY_TABLE [TABLE_SIZE] = '{
        7'h20, 7'h39, 7'h0d, 7'h30, 7'h40, 7'h23, 7'h51, 7'h24,
        7'h35, 7'h36, 7'h38, 7'h37, 7'h31, 7'h32, 7'h34, 7'h33,
        7'h20, 7'h2d, 7'h20, 7'h6c, 7'h57, 7'h45, 7'h71, 7'h52,
        7'h2b, 7'h3c, 7'h3e, 7'h2e, 7'h2a, 7'h2f, 7'h08, 7'h21,
        7'h20, 7'h39, 7'h0d, 7'h30, 7'h40, 7'h23, 7'h7e, 7'h24,
        7'h35, 7'h36, 7'h38, 7'h37, 7'h31, 7'h32, 7'h34, 7'h33
    };

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [6:0] wr_data;
    } t_ring_ctrl;

    typedef struct packed {
        logic [RING_AW-1:0] count;
        logic               empty;
        logic               full;
    } t_ring_stat;

    function automatic logic [6:0] key_lookup(input logic [7:0] idx);
        logic [6:0] key;
        key = KEY_SPACE;
        if (idx < 8'(TABLE_SIZE)) begin
            key = KEY_TABLE[idx[5:0]];
        end
        return key;
    endfunction

    // Anything that is not a hex digit counts as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = 4'(c[3:0] + 4'd9);
        end
        return v;
    endfunction

endpackage

### hdl/krkf_ring.sv
module krkf_ring (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  krkf_pkg::t_ring_ctrl  i_ctrl,
    output krkf_pkg::t_ring_stat  o_stat,
    output logic [6:0]            o_rd_data
);

    localparam logic [krkf_pkg::RING_AW-1:0] LAST_SLOT =
        krkf_pkg::RING_AW'(krkf_pkg::RING_DEPTH - 1);

    logic [6:0]                   r_ring [krkf_pkg::RING_DEPTH];
    logic [krkf_pkg::RING_AW-1:0] r_wr_ptr;
    logic [krkf_pkg::RING_AW-1:0] r_rd_ptr;
    logic [krkf_pkg::RING_AW-1:0] r_count;
    logic [6:0]                   r_rd_data;
    logic [krkf_pkg::RING_AW-1:0] n_wr_ptr;
    logic [krkf_pkg::RING_AW-1:0] n_rd_ptr;

    assign n_wr_ptr = (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;

    // One slot stays free, so full means the write pointer would catch up.
    assign o_stat.count = r_count;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (n_wr_ptr == r_rd_ptr);
    assign o_rd_data    = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_ctrl.push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_ctrl.pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_ctrl.push, i_ctrl.pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_ring[r_wr_ptr] <= i_ctrl.wr_data;
        end
        if (i_ctrl.pop) begin
            r_rd_data <= r_ring[r_rd_ptr];
        end
    end

endmodule

### hdl/keypad_reply_key_fifo_top.sv
// Channel   Dir  Word contents
// s_axis    in   tdata: rx_char; tuser: req_type, rx_first, crc_good; tlast: rx_final
// m_axis    out  tdata: key_code, keys_waiting, good_replies, bad_replies;
//                tuser: key_valid, reply_good; tlast: reply_done
// cfg       in   i_cfg_data: crc_check_enable
//
// One word in, one word out; a new word is taken every cycle while the output register is empty or being drained.
// The result appears in the output register on the cycle after acceptance.
// s_axis_tready is high while the output register is empty or being drained.
// Reset is synchronous, active low; CRC checking comes up enabled.
// The config port is always ready.
`include "assert_macros.svh"

module keypad_reply_key_fifo_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_char
    input  logic [2:0]  s_axis_tuser,   // [0] req_type, [1] rx_first, [2] crc_good
    input  logic        s_axis_tlast,   // rx_final
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [6:0] key_code, [10:7] keys_waiting,
                                        // [26:11] good_replies, [42:27] bad_replies
    output logic [1:0]  m_axis_tuser,   // [0] key_valid, [1] reply_good
    output logic        m_axis_tlast    // reply_done
);

    logic        r_crc_en;
    logic [6:0]  r_char_pos, n_char_pos;
    logic [7:0]  r_pend_idx, n_pend_idx;
    logic        r_pend_full, n_pend_full;
    logic        r_reply_ok, n_reply_ok;
    logic        r_parse_stop, n_parse_stop;
    logic [15:0] r_good_cnt, n_good_cnt;
    logic [15:0] r_bad_cnt, n_bad_cnt;
    logic        r_out_valid, n_out_valid;
    logic        r_key_valid, n_key_valid;
    logic        r_done, n_done;
    logic        r_good, n_good;

    logic                 s_acc;
    logic [3:0]           w_hex;
    logic [6:0]           w_rd_data;
    logic [krkf_pkg::RING_AW+3:0] w_wait_ext;
    krkf_pkg::t_ring_ctrl w_ctrl;
    krkf_pkg::t_ring_stat w_stat;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign w_hex         = krkf_pkg::hex_value(s_axis_tdata);

    krkf_ring u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl),
        .o_stat    (w_stat),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_char_pos   = r_char_pos;
        n_pend_idx   = r_pend_idx;
        n_pend_full  = r_pend_full;
        n_reply_ok   = r_reply_ok;
        n_parse_stop = r_parse_stop;
        n_good_cnt   = r_good_cnt;
        n_bad_cnt    = r_bad_cnt;
        n_key_valid  = r_key_valid;
        n_done       = r_done;
        n_good       = r_good;
        n_out_valid  = r_out_valid && !m_axis_tready;
        w_ctrl       = '0;
        w_ctrl.wr_data = krkf_pkg::key_lookup(r_pend_idx);

        if (s_acc) begin
            n_out_valid = 1'b1;
            n_key_valid = 1'b0;
            n_done      = 1'b0;
            n_good      = 1'b0;
            if (s_axis_tuser[0]) begin
                w_ctrl.pop  = !w_stat.empty;
                n_key_valid = !w_stat.empty;
            end else begin
                if (s_axis_tuser[1]) begin
                    n_char_pos   = '0;
                    n_pend_idx   = '0;
                    n_pend_full  = 1'b0;
                    n_parse_stop = 1'b0;
                    n_reply_ok   = (s_axis_tdata == krkf_pkg::CHAR_BANG) &&
                                   (!r_crc_en || s_axis_tuser[2]);
                end
                // A NUL drops any completed pair and ends parsing.
                if (s_axis_tdata == krkf_pkg::CHAR_NUL) begin
                    n_pend_full  = 1'b0;
                    n_parse_stop = 1'b1;
                end
                // Push a pair only once another character has followed it.
                if (n_pend_full) begin
                    if (n_reply_ok && !n_parse_stop) begin
                        if (w_stat.full) begin
                            n_parse_stop = 1'b1;
                        end else begin
                            w_ctrl.push = 1'b1;
                        end
                    end
                    n_pend_full = 1'b0;
                end
                if (n_char_pos == krkf_pkg::POS_MAX) begin
                    n_parse_stop = 1'b1;
                end else if (n_char_pos >= krkf_pkg::PAIR_START && !n_parse_stop) begin
                    if (!n_char_pos[0]) begin
                        n_pend_idx = {w_hex, 4'd0};
                    end else begin
                        n_pend_idx  = {n_pend_idx[7:4], w_hex};
                        n_pend_full = 1'b1;
                    end
                end
                if (n_char_pos != krkf_pkg::POS_MAX) begin
                    n_char_pos = n_char_pos + 1'b1;
                end
                if (s_axis_tlast) begin
                    n_done = 1'b1;
                    if (n_reply_ok) begin
                        n_good = 1'b1;
                        if (r_good_cnt != 16'hffff) begin
                            n_good_cnt = r_good_cnt + 1'b1;
                        end
                    end else if (r_bad_cnt != 16'hffff) begin
                        n_bad_cnt = r_bad_cnt + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_en     <= 1'b1;
            r_char_pos   <= '0;
            r_pend_idx   <= '0;
            r_pend_full  <= 1'b0;
            r_reply_ok   <= 1'b0;
            r_parse_stop <= 1'b0;
            r_good_cnt   <= '0;
            r_bad_cnt    <= '0;
            r_out_valid  <= 1'b0;
            r_key_valid  <= 1'b0;
            r_done       <= 1'b0;
            r_good       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_crc_en <= i_cfg_data;
            end
            r_char_pos   <= n_char_pos;
            r_pend_idx   <= n_pend_idx;
            r_pend_full  <= n_pend_full;
            r_reply_ok   <= n_reply_ok;
            r_parse_stop <= n_parse_stop;
            r_good_cnt   <= n_good_cnt;
            r_bad_cnt    <= n_bad_cnt;
            r_out_valid  <= n_out_valid;
            r_key_valid  <= n_key_valid;
            r_done       <= n_done;
            r_good       <= n_good;
        end
    end

    assign w_wait_ext    = {4'd0, w_stat.count};
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_done;
    assign m_axis_tuser  = {r_good, r_key_valid};
    assign m_axis_tdata  = {5'd0, r_bad_cnt, r_good_cnt, w_wait_ext[3:0],
                            r_key_valid ? w_rd_data : 7'd0};

    `ASSERT_NEXT(a_pop_drains, s_acc && s_axis_tuser[0] && !w_stat.empty, w_stat.count == $past(w_stat.count) - 1'b1 && r_key_valid, "pop did not take one key")
    `ASSERT_NEXT(a_pop_empty, s_acc && s_axis_tuser[0] && w_stat.empty, !r_key_valid && w_stat.empty, "pop on empty ring returned a key")
    `ASSERT_HOLDS(a_good_done, !r_good || r_done, "reply_good without reply_done")
    `ASSERT_HOLDS(a_key_not_reply, !(r_key_valid && r_done), "key and reply end in one word")

endmodule
